// ===== design/tcf_pkg.sv =====
// Shared types, constants and a helper function for the tilt complementary filter.
`timescale 1ns / 1ps
`default_nettype none
package tcf_pkg;

   localparam int unsigned CfgIdxW = 3;
   localparam int unsigned CfgW    = 32;

   typedef enum logic [CfgIdxW-1:0] {
      REG_PITCH_A1 = 3'd0,
      REG_PITCH_B0 = 3'd1,
      REG_PITCH_B1 = 3'd2,
      REG_PITCH_RS = 3'd3,
      REG_ROLL_A1  = 3'd4,
      REG_ROLL_B0  = 3'd5,
      REG_ROLL_B1  = 3'd6,
      REG_ROLL_RS  = 3'd7
   } reg_idx_type;

   localparam logic signed [31:0] RstA1 = -32'sd1071916463;
   localparam logic signed [31:0] RstB  = 32'sd893686;
   localparam logic signed [31:0] RstRs = 32'sd65536;

   localparam logic signed [37:0] Deg180 = 38'sd11796480;
   localparam logic signed [37:0] Deg90  = 38'sd5898240;

   // One IMU sample as queued between front and back.
   typedef struct packed {
      logic signed [15:0] rate_x;
      logic signed [15:0] rate_y;
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
   } sample_type;

   typedef struct packed {
      logic signed [24:0] tilt_pitch;
      logic signed [24:0] tilt_roll;
      logic signed [31:0] smooth_pitch;
      logic signed [31:0] smooth_roll;
   } result_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQRT,
      ST_PCOR,
      ST_RCOR,
      ST_URATE,
      ST_P_FB,
      ST_P_W,
      ST_P_B0,
      ST_P_B1,
      ST_R_FB,
      ST_R_W,
      ST_R_B0,
      ST_R_B1,
      ST_OUT
   } state_type;

   // atan(2^-i) in degrees, Q16.16
   function automatic logic [21:0] atan_deg(input logic [4:0] i);
      logic [21:0] r;
      begin
         unique case (i)
            5'd0:  r = 22'd2949120;
            5'd1:  r = 22'd1740967;
            5'd2:  r = 22'd919879;
            5'd3:  r = 22'd466945;
            5'd4:  r = 22'd234379;
            5'd5:  r = 22'd117304;
            5'd6:  r = 22'd58666;
            5'd7:  r = 22'd29335;
            5'd8:  r = 22'd14668;
            5'd9:  r = 22'd7334;
            5'd10: r = 22'd3667;
            5'd11: r = 22'd1833;
            5'd12: r = 22'd917;
            5'd13: r = 22'd458;
            5'd14: r = 22'd229;
            5'd15: r = 22'd115;
            5'd16: r = 22'd57;
            5'd17: r = 22'd29;
            5'd18: r = 22'd14;
            5'd19: r = 22'd7;
            5'd20: r = 22'd4;
            5'd21: r = 22'd2;
            5'd22: r = 22'd1;
            default: r = 22'd0;
         endcase
         return r;
      end
   endfunction

endpackage
`default_nettype wire

// ===== design/tcf_queue.sv =====
// Short sample queue between the accepting front and the computing back.
`timescale 1ns / 1ps
`default_nettype none
module tcf_queue
   import tcf_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  sample_type      push_data,
   output logic            full,
   input  wire logic       pop,
   output sample_type      pop_data,
   output logic            empty
);
   sample_type  mem_ff [2];
   logic        wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]  cnt_ff, cnt_in;

   assign full     = (cnt_ff == 2'd2);
   assign empty    = (cnt_ff == 2'd0);
   assign pop_data = mem_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= push_data;
   end
endmodule
`default_nettype wire

// ===== design/tcf_back.sv =====
// Back end: square root, shared CORDIC, rate mix and both IIR filter steps.
`timescale 1ns / 1ps
`default_nettype none
module tcf_back
   import tcf_pkg::*;
#(
   parameter int unsigned CORDIC_STEPS = 20
)(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_empty,
   input  sample_type             q_data,
   output logic                   q_pop,
   input  wire logic              clr,
   input  wire logic signed [31:0] p_a1, p_b0, p_b1, p_rs,
   input  wire logic signed [31:0] r_a1, r_b0, r_b1, r_rs,
   output logic                   res_valid,
   input  wire logic              res_ready,
   output result_type             res_data
);
   localparam int unsigned StepW = $clog2(CORDIC_STEPS + 1);

   state_type st_ff, st_in;
   sample_type smp_ff;
   logic [StepW-1:0] step_ff;
   logic [4:0]  sq_ff;          // square root iteration
   logic [49:0] rem_ff;         // radicand remainder
   logic [49:0] root_ff;        // partial root; ends as the Q16.8 magnitude
   logic signed [37:0] cx_ff, cy_ff, cz_ff;
   logic signed [24:0] tp_ff, tr_ff;
   logic signed [49:0] up_ff, ur_ff;
   logic signed [47:0] pdel_ff, rdel_ff, w_ff;
   logic signed [63:0] acc_ff;
   logic signed [31:0] sp_ff, sr_ff;
   result_type res_ff;
   logic valid_ff, valid_in;

   logic signed [37:0] cx_in, cy_in, cz_in;
   logic signed [37:0] zcl;
   logic signed [63:0] mul_res;
   logic signed [31:0] mul_a;
   logic signed [47:0] mul_b;
   logic [49:0] trial;
   logic [49:0] radicand;
   logic [49:0] rem_cur;

   // floor(a*b / 2^30) over a 32 x 48 product, split into two 32 x 24 halves
   function automatic logic signed [63:0] mulq30(input logic signed [31:0] a,
                                                  input logic signed [47:0] b);
      logic signed [79:0] p;
      begin
         p = $signed(a) * $signed({{8{1'b0}}, b[23:0]}) +
             (($signed(a) * $signed(b[47:24])) <<< 24);
         return 64'(p >>> 30);
      end
   endfunction

   assign mul_res = mulq30(mul_a, mul_b);

   always_comb begin
      mul_a = p_a1;
      mul_b = pdel_ff;
      unique case (st_ff)
         ST_P_FB: begin mul_a = p_a1; mul_b = pdel_ff; end
         ST_P_B0: begin mul_a = p_b0; mul_b = w_ff;    end
         ST_P_B1: begin mul_a = p_b1; mul_b = pdel_ff; end
         ST_R_FB: begin mul_a = r_a1; mul_b = rdel_ff; end
         ST_R_B0: begin mul_a = r_b0; mul_b = w_ff;    end
         ST_R_B1: begin mul_a = r_b1; mul_b = rdel_ff; end
         default: begin mul_a = p_a1; mul_b = pdel_ff; end
      endcase
   end

   // one CORDIC rotation
   always_comb begin
      if (!cy_ff[37]) begin
         cx_in = cx_ff + (cy_ff >>> step_ff);
         cy_in = cy_ff - (cx_ff >>> step_ff);
         cz_in = cz_ff + $signed({16'd0, atan_deg(5'(step_ff))});
      end else begin
         cx_in = cx_ff - (cy_ff >>> step_ff);
         cy_in = cy_ff + (cx_ff >>> step_ff);
         cz_in = cz_ff - $signed({16'd0, atan_deg(5'(step_ff))});
      end
      zcl = (cz_ff > Deg180) ? Deg180 : ((cz_ff < -Deg180) ? -Deg180 : cz_ff);
   end

   assign trial = root_ff + (50'd1 << {sq_ff, 1'b0});
   assign radicand = 50'(($signed(smp_ff.accel_y) * $signed(smp_ff.accel_y)) +
                         ($signed(smp_ff.accel_z) * $signed(smp_ff.accel_z))) << 16;
   assign rem_cur = (sq_ff == 5'd24) ? radicand : rem_ff;

   assign q_pop     = (st_ff == ST_IDLE) && !q_empty;
   assign res_valid = valid_ff;
   assign res_data  = res_ff;

   always_comb begin
      valid_in = valid_ff;
      if (valid_ff && res_ready) valid_in = 1'b0;
      if ((st_ff == ST_OUT) && (!valid_ff || res_ready)) valid_in = 1'b1;
   end

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE:  if (!q_empty) st_in = ST_SQRT;
         ST_SQRT:  if (sq_ff == 5'd0) st_in = ST_PCOR;
         ST_PCOR:  if (step_ff == StepW'(CORDIC_STEPS)) st_in = ST_RCOR;
         ST_RCOR:  if (step_ff == StepW'(CORDIC_STEPS)) st_in = ST_URATE;
         ST_URATE: st_in = ST_P_FB;
         ST_P_FB:  st_in = ST_P_W;
         ST_P_W:   st_in = ST_P_B0;
         ST_P_B0:  st_in = ST_P_B1;
         ST_P_B1:  st_in = ST_R_FB;
         ST_R_FB:  st_in = ST_R_W;
         ST_R_W:   st_in = ST_R_B0;
         ST_R_B0:  st_in = ST_R_B1;
         ST_R_B1:  st_in = ST_OUT;
         ST_OUT:   if (!valid_ff || res_ready) st_in = ST_IDLE;
         default:  st_in = ST_IDLE;
      endcase
   end

   function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
      return (v > 64'sh7FFF_FFFF_FFFF) ? 48'sh7FFF_FFFF_FFFF :
             (v < -64'sh8000_0000_0000) ? 48'sh8000_0000_0000 : v[47:0];
   endfunction
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      return (v > 64'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
             (v < -64'sh8000_0000) ? 32'sh8000_0000 : v[31:0];
   endfunction

   // preload CORDIC with quadrant fold
   task automatic load_cordic(input logic signed [37:0] y, input logic signed [37:0] x);
      begin
         step_ff <= '0;
         if (x < 0) begin
            if (!y[37]) begin cx_ff <= y; cy_ff <= -x; cz_ff <= Deg90; end
            else begin cx_ff <= -y; cy_ff <= x; cz_ff <= -Deg90; end
         end else begin
            cx_ff <= x; cy_ff <= y; cz_ff <= '0;
         end
      end
   endtask

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= ST_IDLE;
         valid_ff <= 1'b0;
         pdel_ff  <= '0;
         rdel_ff  <= '0;
      end else begin
         st_ff    <= st_in;
         valid_ff <= valid_in;
         if (clr) begin
            pdel_ff <= '0;
            rdel_ff <= '0;
         end
         unique case (st_ff)
            ST_IDLE: if (!q_empty) begin
               smp_ff  <= q_data;
               sq_ff   <= 5'd24;
               root_ff <= '0;
            end
            ST_SQRT: begin
               if (rem_cur >= trial) begin
                  rem_ff  <= rem_cur - trial;
                  root_ff <= (root_ff >> 1) + (50'd1 << {sq_ff, 1'b0});
               end else begin
                  rem_ff  <= rem_cur;
                  root_ff <= root_ff >> 1;
               end
               if (sq_ff != 5'd0) sq_ff <= sq_ff - 5'd1;
               else load_cordic(38'(smp_ff.accel_y) <<< 14, 38'(smp_ff.accel_z) <<< 14);
            end
            ST_PCOR: begin
               if (step_ff == StepW'(CORDIC_STEPS)) begin
                  // zero vector gives zero angle
                  tp_ff <= (smp_ff.accel_y == 16'sd0 && smp_ff.accel_z == 16'sd0) ?
                           '0 : zcl[24:0];
                  load_cordic(-(38'(smp_ff.accel_x) <<< 14), 38'({root_ff[25:0], 6'd0}));
               end else begin
                  cx_ff <= cx_in; cy_ff <= cy_in; cz_ff <= cz_in;
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_RCOR: begin
               if (step_ff == StepW'(CORDIC_STEPS)) begin
                  tr_ff <= (smp_ff.accel_x == 16'sd0 && root_ff == 50'd0) ? '0 : zcl[24:0];
               end else begin
                  cx_ff <= cx_in; cy_ff <= cy_in; cz_ff <= cz_in;
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_URATE: begin
               up_ff <= 50'(tp_ff) - 50'(($signed(p_rs) * $signed(smp_ff.rate_y)) >>> 4);
               ur_ff <= 50'(tr_ff) + 50'(($signed(r_rs) * $signed(smp_ff.rate_x)) >>> 4);
            end
            ST_P_FB, ST_R_FB: acc_ff <= mul_res;
            ST_P_W:  w_ff <= sat48(64'(up_ff) - acc_ff);
            ST_R_W:  w_ff <= sat48(64'(ur_ff) - acc_ff);
            ST_P_B0, ST_R_B0: acc_ff <= mul_res;
            ST_P_B1: begin
               sp_ff <= sat32(acc_ff + mul_res);
               if (!clr) pdel_ff <= w_ff;
            end
            ST_R_B1: begin
               sr_ff <= sat32(acc_ff + mul_res);
               if (!clr) rdel_ff <= w_ff;
            end
            // load the result register only once the previous word has left
            ST_OUT: if (!valid_ff || res_ready) begin
               res_ff.smooth_roll  <= sr_ff;
               res_ff.smooth_pitch <= sp_ff;
               res_ff.tilt_pitch   <= tp_ff;
               res_ff.tilt_roll    <= tr_ff;
            end
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== design/tilt_complementary_filter.sv =====
// Top level of the tilt complementary filter: front end, queue, back end, registers.
//  channel | dir | handshake             | word
//  req_    | in  | req_tvalid/req_tready | 80-bit sample
//  rsp_    | out | rsp_tvalid/rsp_tready | 120-bit result
//  csr_    | in  | csr_we                | 32-bit register write
// Each sample passes through the bit-serial square root and then the shared
// CORDIC rotator, which handles pitch then roll.
// Reset is synchronous; it restores default coefficients and clears filter delays.
// A two-entry queue holds samples while the back end works; the result holds
// in its register until rsp_tready.
`timescale 1ns / 1ps
`default_nettype none
module tilt_complementary_filter
   import tcf_pkg::*;
#(
   parameter int unsigned CORDIC_STEPS = 20
)(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // rate_x, rate_y, accel_x, accel_y, accel_z
   input  wire logic [79:0]  req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // tilt_pitch, tilt_roll, smooth_pitch, smooth_roll (114 bits, zero-filled)
   output logic [119:0]      rsp_tdata,
   input  wire logic         csr_we,
   input  wire logic [2:0]   csr_idx,
   input  wire logic [31:0]  csr_wdata
);
   logic signed [31:0] cfg_ff [8];
   sample_type smp, qd;
   logic full, empty, pop;
   result_type res;

   assign smp.rate_x  = req_tdata[15:0];
   assign smp.rate_y  = req_tdata[31:16];
   assign smp.accel_x = req_tdata[47:32];
   assign smp.accel_y = req_tdata[63:48];
   assign smp.accel_z = req_tdata[79:64];
   assign req_tready  = !full;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[REG_PITCH_A1] <= RstA1;
         cfg_ff[REG_PITCH_B0] <= RstB;
         cfg_ff[REG_PITCH_B1] <= RstB;
         cfg_ff[REG_PITCH_RS] <= RstRs;
         cfg_ff[REG_ROLL_A1]  <= RstA1;
         cfg_ff[REG_ROLL_B0]  <= RstB;
         cfg_ff[REG_ROLL_B1]  <= RstB;
         cfg_ff[REG_ROLL_RS]  <= RstRs;
      end else if (csr_we) begin
         cfg_ff[csr_idx] <= csr_wdata;
      end
   end

   tcf_queue u_queue (
      .clock, .reset,
      .push(req_tvalid && !full), .push_data(smp), .full,
      .pop, .pop_data(qd), .empty
   );

   tcf_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
      .clock, .reset,
      .q_empty(empty), .q_data(qd), .q_pop(pop),
      .clr(csr_we),
      .p_a1(cfg_ff[REG_PITCH_A1]), .p_b0(cfg_ff[REG_PITCH_B0]),
      .p_b1(cfg_ff[REG_PITCH_B1]), .p_rs(cfg_ff[REG_PITCH_RS]),
      .r_a1(cfg_ff[REG_ROLL_A1]),  .r_b0(cfg_ff[REG_ROLL_B0]),
      .r_b1(cfg_ff[REG_ROLL_B1]),  .r_rs(cfg_ff[REG_ROLL_RS]),
      .res_valid(rsp_tvalid), .res_ready(rsp_tready), .res_data(res)
   );

   assign rsp_tdata = {6'd0, res.smooth_roll, res.smooth_pitch, res.tilt_roll, res.tilt_pitch};
endmodule
`default_nettype wire

// ===== tb/sv/tb_tilt_complementary_filter.sv =====
// Testbench for the tilt complementary filter: predicts each result and checks it.
`timescale 1ns / 1ps

// Holds the predicted results and the filter state that produces them.
class tilt_scoreboard;
   localparam int CordicSteps = 20;
   localparam longint Deg180Q16 = 11796480;
   localparam longint Deg90Q16 = 5898240;

   longint coef[8];
   longint pitch_w, roll_w;
   logic [113:0] predicted[$];
   int errors;
   int checked;

   function new();
      coef[tcf_pkg::REG_PITCH_A1] = -1071916463;
      coef[tcf_pkg::REG_PITCH_B0] = 893686;
      coef[tcf_pkg::REG_PITCH_B1] = 893686;
      coef[tcf_pkg::REG_PITCH_RS] = 65536;
      coef[tcf_pkg::REG_ROLL_A1] = -1071916463;
      coef[tcf_pkg::REG_ROLL_B0] = 893686;
      coef[tcf_pkg::REG_ROLL_B1] = 893686;
      coef[tcf_pkg::REG_ROLL_RS] = 65536;
      pitch_w = 0;
      roll_w = 0;
      errors = 0;
      checked = 0;
   endfunction

   function void write_reg(tcf_pkg::reg_idx_type idx, logic [31:0] val);
      coef[idx] = longint'(signed'(val));
      pitch_w = 0;
      roll_w = 0;
   endfunction

   function automatic longint sat_to(longint v, int w);
      longint hi, lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      return v > hi ? hi : (v < lo ? lo : v);
   endfunction

   // floor(a * b / 2^30) carried out at full width
   function automatic longint q30_product(longint a, longint b);
      logic signed [127:0] p;
      p = 128'(signed'(a)) * 128'(signed'(b));
      return longint'(p >>> 30);
   endfunction

   function automatic longint int_sqrt(longint unsigned n);
      longint unsigned res, bt;
      res = 0;
      bt = 64'd1 << 62;
      while (bt > n) bt = bt >> 2;
      while (bt != 0) begin
         if (n >= res + bt) begin
            n = n - (res + bt);
            res = (res >> 1) + bt;
         end else begin
            res = res >> 1;
         end
         bt = bt >> 2;
      end
      return longint'(res);
   endfunction

   function automatic longint vector_angle(longint y, longint x);
      longint tab[23] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                          29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
                          14, 7, 4, 2, 1};
      longint z, t, dx, dy;
      z = 0;
      if (x == 0 && y == 0) return 0;
      // swing a left-half vector into the right half first
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y; y = -t; z = Deg90Q16;
         end else begin
            x = -y; y = t; z = -Deg90Q16;
         end
      end
      for (int i = 0; i < CordicSteps; i++) begin
         dx = x >>> i;
         dy = y >>> i;
         if (y >= 0) begin
            x += dy; y -= dx; z += (i < 23) ? tab[i] : 0;
         end else begin
            x -= dy; y += dx; z -= (i < 23) ? tab[i] : 0;
         end
      end
      return sat_to(z > Deg180Q16 ? Deg180Q16 : (z < -Deg180Q16 ? -Deg180Q16 : z), 64);
   endfunction

   function automatic longint iir_step(ref longint dly, input longint u, longint a1,
                                       longint b0, longint b1);
      longint w, o;
      w = sat_to(u - q30_product(a1, dly), 48);
      o = sat_to(q30_product(b0, w) + q30_product(b1, dly), 32);
      dly = w;
      return o;
   endfunction

   // Predict the result word for one accepted sample word.
   function void note_sample(logic [79:0] d);
      longint rx, ry, ax, ay, az, tp, tr, mag, sp, sr;
      logic [113:0] r;
      rx = longint'(signed'(d[15:0]));
      ry = longint'(signed'(d[31:16]));
      ax = longint'(signed'(d[47:32]));
      ay = longint'(signed'(d[63:48]));
      az = longint'(signed'(d[79:64]));
      tp = vector_angle(ay * 16384, az * 16384);
      mag = int_sqrt(longint'(ay * ay + az * az) << 16);
      tr = vector_angle(-ax * 16384, mag * 64);
      sp = iir_step(pitch_w, tp - ((coef[tcf_pkg::REG_PITCH_RS] * ry) >>> 4),
                    coef[tcf_pkg::REG_PITCH_A1], coef[tcf_pkg::REG_PITCH_B0],
                    coef[tcf_pkg::REG_PITCH_B1]);
      sr = iir_step(roll_w, tr + ((coef[tcf_pkg::REG_ROLL_RS] * rx) >>> 4),
                    coef[tcf_pkg::REG_ROLL_A1], coef[tcf_pkg::REG_ROLL_B0],
                    coef[tcf_pkg::REG_ROLL_B1]);
      r = {sr[31:0], sp[31:0], tr[24:0], tp[24:0]};
      predicted.push_back(r);
   endfunction

   function void check_result(logic [119:0] d);
      logic [113:0] e;
      checked++;
      if (predicted.size() == 0) begin
         errors++;
         $display("%0t: unexpected result word %h", $time, d);
         return;
      end
      e = predicted.pop_front();
      if (d[24:0] !== e[24:0]) begin
         errors++;
         $display("%0t: tilt_pitch expected %0d got %0d", $time,
                  signed'(e[24:0]), signed'(d[24:0]));
      end
      if (d[49:25] !== e[49:25]) begin
         errors++;
         $display("%0t: tilt_roll expected %0d got %0d", $time,
                  signed'(e[49:25]), signed'(d[49:25]));
      end
      if (d[81:50] !== e[81:50]) begin
         errors++;
         $display("%0t: smooth_pitch expected %0d got %0d", $time,
                  signed'(e[81:50]), signed'(d[81:50]));
      end
      if (d[113:82] !== e[113:82]) begin
         errors++;
         $display("%0t: smooth_roll expected %0d got %0d", $time,
                  signed'(e[113:82]), signed'(d[113:82]));
      end
   endfunction
endclass

module tb_tilt_complementary_filter;
   import tcf_pkg::*;

   // Generous cycle budget; a clean run needs a small fraction of it.
   localparam int CycleLimit = 1000000;
   // Back-end latency per sample, with margin.
   localparam int DrainCycles = 120;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [79:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [119:0] rsp_tdata;
   logic csr_we;
   logic [2:0] csr_idx;
   logic [31:0] csr_wdata;

   tilt_scoreboard tilt_sb;
   int send_idle_pct;
   int recv_stall_pct;
   bit hold_rsp;
   int cycles;
   int sent;

   tilt_complementary_filter dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_idx(csr_idx), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Timeout watchdog: count cycles and give up past the budget.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Receiver: check each accepted result word, then pick the next ready level.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tilt_sb.check_result(rsp_tdata);
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_rsp) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Offer one sample word and hold it until accepted.
   task automatic send_sample(input logic [15:0] rx, ry, ax, ay, az);
      req_tvalid <= 1'b1;
      req_tdata <= {az, ay, ax, ry, rx};
      do @(posedge clock); while (!req_tready);
      tilt_sb.note_sample({az, ay, ax, ry, rx});
      sent++;
      // idle on the sender side at random, then the next word goes out
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tilt_sb.predicted.size() != 0) @(posedge clock);
   endtask

   // Drive one register write; the caller drops csr_we after the last one.
   task automatic csr_write(input reg_idx_type idx, input logic [31:0] val);
      csr_we <= 1'b1;
      csr_idx <= idx;
      csr_wdata <= val;
      @(posedge clock);
      tilt_sb.write_reg(idx, val);
   endtask

   // Drain, let the back end settle, then load a full coefficient set.
   task automatic load_coefs(input logic [31:0] pa1, pb0, pb1, prs,
                             input logic [31:0] ra1, rb0, rb1, rrs);
      wait_drained();
      repeat (DrainCycles) @(posedge clock);
      csr_write(REG_PITCH_A1, pa1);
      csr_write(REG_PITCH_B0, pb0);
      csr_write(REG_PITCH_B1, pb1);
      csr_write(REG_PITCH_RS, prs);
      csr_write(REG_ROLL_A1, ra1);
      csr_write(REG_ROLL_B0, rb0);
      csr_write(REG_ROLL_B1, rb1);
      csr_write(REG_ROLL_RS, rrs);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly plausible IMU samples near 1 g, with a share of full-range noise.
   task automatic send_random();
      logic [15:0] f[5];
      if ($urandom_range(99) < 70) begin
         f[0] = 16'($urandom_range(4000) - 2000);
         f[1] = 16'($urandom_range(4000) - 2000);
         f[2] = 16'($urandom_range(8192) - 4096);
         f[3] = 16'($urandom_range(8192) - 4096);
         f[4] = 16'($urandom_range(8192) - 4096);
      end else begin
         foreach (f[i]) f[i] = 16'($urandom);
      end
      send_sample(f[0], f[1], f[2], f[3], f[4]);
   endtask

   task automatic random_phase(input int n);
      int idle_set[4] = '{0, 58, 0, 14};
      int stall_set[4] = '{0, 0, 58, 14};
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = idle_set[p];
         recv_stall_pct = stall_set[p];
         repeat (n) send_random();
      end
   endtask

   initial begin
      tilt_sb = new();
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      rsp_tready <= 1'b0;
      csr_we <= 1'b0;
      csr_idx <= REG_PITCH_A1;
      csr_wdata <= '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_rsp = 1'b0;
      cycles = 0;
      sent = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero vector, field extremes, each quadrant of the CORDIC entry.
      send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_sample(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000);
      send_sample(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF);
      send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h1000);
      send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hF000);
      send_sample(16'h0000, 16'h0000, 16'h0000, 16'h1000, 16'hF000);
      send_sample(16'h0000, 16'h0000, 16'h0000, 16'hF000, 16'hF000);
      send_sample(16'h0000, 16'h0000, 16'h1000, 16'h0000, 16'h0000);
      send_sample(16'h0000, 16'h0000, 16'hF000, 16'h0000, 16'h0000);
      send_sample(16'h0010, 16'hFFF0, 16'h0800, 16'h0800, 16'h0E00);
      send_sample(16'hFFFF, 16'h0001, 16'h0001, 16'hFFFF, 16'h0001);
      send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0000);

      // Pressure: hold off the receiver long enough that the input stalls.
      fork
         begin
            hold_rsp = 1'b1;
            repeat (600) @(posedge clock);
            hold_rsp = 1'b0;
         end
      join_none
      repeat (8) send_random();
      wait_drained();

      random_phase(40);
      // extremes of every coefficient
      load_coefs(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
      random_phase(15);
      load_coefs(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
      random_phase(15);
      load_coefs(32'h0, 32'h40000000, 32'h0, 32'h0,
                 32'h0, 32'h40000000, 32'h0, 32'h0);
      random_phase(15);
      load_coefs($urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom);
      random_phase(20);
      // back to the power-on set
      load_coefs(RstA1, RstB, RstB, RstRs, RstA1, RstB, RstB, RstRs);
      random_phase(50);

      wait_drained();
      repeat (DrainCycles) @(posedge clock);
      if (tilt_sb.predicted.size() != 0) begin
         tilt_sb.errors += tilt_sb.predicted.size();
         $display("%0t: %0d expected results never arrived", $time,
                  tilt_sb.predicted.size());
      end
      $display("covered %0d samples, %0d results, six coefficient sets,", sent,
               tilt_sb.checked);
      $display("four idle/stall mixes and one long receiver hold; %0d mismatches",
               tilt_sb.errors);
      if (tilt_sb.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

// ===== files.f =====
design/tcf_pkg.sv
design/tcf_queue.sv
design/tcf_back.sv
design/tilt_complementary_filter.sv
tb/sv/tb_tilt_complementary_filter.sv
